### src/ihq_pkg.sv
// ihq_pkg: shared sizes, codes and types for the indexed binary heap queue
// no dependencies; used by ihq_ctrl, ihq_dp and the top module

package ihq_pkg;

  localparam int MaxEntries = 64;
  localparam int IdW        = 6;
  localparam int PrioW      = 32;
  localparam int CountW     = 7;
  localparam int ModeW      = 3;
  localparam int StatusW    = 3;
  localparam int ChildW     = IdW + 2;
  localparam int SlotW      = IdW + PrioW;

  localparam logic CFG_MIN_ORDER = 1'b0;
  localparam logic CFG_CAPACITY  = 1'b1;

  localparam logic [ModeW-1:0] MODE_INSERT = 3'd0;
  localparam logic [ModeW-1:0] MODE_CHANGE = 3'd1;
  localparam logic [ModeW-1:0] MODE_REMOVE = 3'd2;
  localparam logic [ModeW-1:0] MODE_DELTOP = 3'd3;
  localparam logic [ModeW-1:0] MODE_GET    = 3'd4;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LOOKUP, S_GET, S_TAKE_TOP, S_REMOVE, S_FILL,
    S_UP_RD, S_UP_CMP, S_DOWN_RDL, S_DOWN_RDR, S_DOWN_CMP, S_PLACE,
    S_TOP, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ACCEPT, CMD_DECODE, CMD_LOOKUP, CMD_GET, CMD_TAKE_TOP,
    CMD_REMOVE, CMD_FILL, CMD_UP_RD, CMD_UP_CMP, CMD_DOWN_RDL, CMD_DOWN_RDR,
    CMD_DOWN_CMP, CMD_PLACE, CMD_TOP_RD, CMD_LOAD_OUT
  } cmd_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             dec_insert;
    logic             dec_lookup;
    logic             dec_take;
    logic             pos_zero;
    logic             s_is_last;
    logic             l_in_heap;
    logic             up_swap;
    logic             down_swap;
    logic             out_free;
  } stat_t;

  function automatic logic outranks(logic min_ord, logic signed [PrioW-1:0] a,
                                    logic signed [PrioW-1:0] b);
    return min_ord ? (a < b) : (a > b);
  endfunction

endpackage

### src/ihq_ram.sv
// ihq_ram: generic single-write, single-read ram with registered read data
// no dependencies

module ihq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ihq_ctrl.sv
// ihq_ctrl: sequencer for the heap operations and the sift walks
// depends on ihq_pkg

module ihq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ihq_pkg::stat_t stat_i,
  output ihq_pkg::cmd_e  cmd_o
);

  ihq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ihq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = ihq_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ihq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = ihq_pkg::CMD_ACCEPT;
          state_d = ihq_pkg::S_DECODE;
        end
      end
      ihq_pkg::S_DECODE: begin
        cmd_o = ihq_pkg::CMD_DECODE;
        if (stat_i.dec_insert) begin
          state_d = ihq_pkg::S_UP_RD;
        end else if (stat_i.dec_lookup) begin
          state_d = ihq_pkg::S_LOOKUP;
        end else if (stat_i.dec_take) begin
          state_d = ihq_pkg::S_TAKE_TOP;
        end else begin
          state_d = ihq_pkg::S_TOP;
        end
      end
      ihq_pkg::S_LOOKUP: begin
        cmd_o = ihq_pkg::CMD_LOOKUP;
        if (stat_i.mode == ihq_pkg::MODE_CHANGE) begin
          state_d = ihq_pkg::S_UP_RD;
        end else if (stat_i.mode == ihq_pkg::MODE_GET) begin
          state_d = ihq_pkg::S_GET;
        end else begin
          state_d = ihq_pkg::S_REMOVE;
        end
      end
      ihq_pkg::S_GET: begin
        cmd_o   = ihq_pkg::CMD_GET;
        state_d = ihq_pkg::S_TOP;
      end
      ihq_pkg::S_TAKE_TOP: begin
        cmd_o   = ihq_pkg::CMD_TAKE_TOP;
        state_d = ihq_pkg::S_REMOVE;
      end
      ihq_pkg::S_REMOVE: begin
        cmd_o   = ihq_pkg::CMD_REMOVE;
        state_d = stat_i.s_is_last ? ihq_pkg::S_TOP : ihq_pkg::S_FILL;
      end
      ihq_pkg::S_FILL: begin
        cmd_o   = ihq_pkg::CMD_FILL;
        state_d = ihq_pkg::S_UP_RD;
      end
      ihq_pkg::S_UP_RD: begin
        cmd_o   = ihq_pkg::CMD_UP_RD;
        state_d = stat_i.pos_zero ? ihq_pkg::S_DOWN_RDL : ihq_pkg::S_UP_CMP;
      end
      ihq_pkg::S_UP_CMP: begin
        cmd_o   = ihq_pkg::CMD_UP_CMP;
        state_d = stat_i.up_swap ? ihq_pkg::S_UP_RD : ihq_pkg::S_DOWN_RDL;
      end
      ihq_pkg::S_DOWN_RDL: begin
        cmd_o   = ihq_pkg::CMD_DOWN_RDL;
        state_d = stat_i.l_in_heap ? ihq_pkg::S_DOWN_RDR : ihq_pkg::S_PLACE;
      end
      ihq_pkg::S_DOWN_RDR: begin
        cmd_o   = ihq_pkg::CMD_DOWN_RDR;
        state_d = ihq_pkg::S_DOWN_CMP;
      end
      ihq_pkg::S_DOWN_CMP: begin
        cmd_o   = ihq_pkg::CMD_DOWN_CMP;
        state_d = stat_i.down_swap ? ihq_pkg::S_DOWN_RDL : ihq_pkg::S_PLACE;
      end
      ihq_pkg::S_PLACE: begin
        cmd_o   = ihq_pkg::CMD_PLACE;
        state_d = ihq_pkg::S_TOP;
      end
      ihq_pkg::S_TOP: begin
        cmd_o   = ihq_pkg::CMD_TOP_RD;
        state_d = ihq_pkg::S_DONE;
      end
      ihq_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o   = ihq_pkg::CMD_LOAD_OUT;
          state_d = ihq_pkg::S_IDLE;
        end
      end
      default: state_d = ihq_pkg::S_IDLE;
    endcase
  end

endmodule

### src/ihq_dp.sv
// ihq_dp: heap datapath with slot and id-map rams, presence bits and result register
// depends on ihq_pkg and ihq_ram

module ihq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_index_i,
  input  logic [ihq_pkg::CountW-1:0]    cfg_data_i,
  input  logic [ihq_pkg::ModeW-1:0]     mode_i,
  input  logic [ihq_pkg::IdW-1:0]       entry_id_i,
  input  logic signed [ihq_pkg::PrioW-1:0] new_priority_i,
  input  ihq_pkg::cmd_e                 cmd_i,
  output ihq_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ihq_pkg::StatusW-1:0]   status_o,
  output logic [ihq_pkg::IdW-1:0]       answer_id_o,
  output logic signed [ihq_pkg::PrioW-1:0] answer_priority_o,
  output logic                          top_valid_o,
  output logic [ihq_pkg::IdW-1:0]       top_id_o,
  output logic signed [ihq_pkg::PrioW-1:0] top_priority_o,
  output logic [ihq_pkg::CountW-1:0]    entry_count_o
);

  localparam int IdW = ihq_pkg::IdW;
  localparam int PrioW = ihq_pkg::PrioW;
  localparam int CountW = ihq_pkg::CountW;
  localparam int ChildW = ihq_pkg::ChildW;
  localparam int SlotW = ihq_pkg::SlotW;

  logic                     min_order_q;
  logic [CountW-1:0]        cap_q;
  logic [ihq_pkg::ModeW-1:0] mode_q;
  logic [IdW-1:0]           id_q;
  logic signed [PrioW-1:0]  prio_q;
  logic [ihq_pkg::MaxEntries-1:0] present_q;
  logic [CountW-1:0]        held_q;
  logic signed [PrioW-1:0]  cur_prio_q;
  logic [IdW-1:0]           cur_owner_q;
  logic [IdW-1:0]           pos_q;
  logic signed [PrioW-1:0]  left_prio_q;
  logic [IdW-1:0]           left_owner_q;
  logic                     has_right_q;
  ihq_pkg::status_e         st_q;
  logic [IdW-1:0]           ans_id_q;
  logic signed [PrioW-1:0]  ans_prio_q;

  logic                     out_valid_q;
  logic [ihq_pkg::StatusW-1:0] out_status_q;
  logic [IdW-1:0]           out_ans_id_q;
  logic signed [PrioW-1:0]  out_ans_prio_q;
  logic                     out_top_valid_q;
  logic [IdW-1:0]           out_top_id_q;
  logic signed [PrioW-1:0]  out_top_prio_q;
  logic [CountW-1:0]        out_count_q;

  logic             slot_we, slot_re, id_we, id_re;
  logic [IdW-1:0]   slot_waddr, slot_raddr, id_waddr, id_raddr;
  logic [SlotW-1:0] slot_wdata, slot_rdata;
  logic [IdW-1:0]   id_wdata, id_rdata;

  logic signed [PrioW-1:0] rd_prio, child_prio;
  logic [IdW-1:0]   rd_owner, child_owner, parent, child_idx;
  logic [CountW-1:0] last;
  logic [ChildW-1:0] lchild, rchild;
  logic             in_range, id_here, s_is_last, l_in_heap, r_in_heap;
  logic             up_swap, right_wins, down_swap, valid_op, lookup_op;
  logic [CountW-1:0] cap_clamped;

  assign rd_prio   = slot_rdata[PrioW-1:0];
  assign rd_owner  = slot_rdata[SlotW-1:PrioW];
  assign in_range  = {1'b0, id_q} < cap_q;
  assign id_here   = present_q[id_q];
  assign last      = held_q - CountW'(1);
  assign s_is_last = {1'b0, pos_q} == last;
  assign parent    = (pos_q - IdW'(1)) >> 1;
  assign lchild    = {1'b0, pos_q, 1'b1};
  assign rchild    = lchild + ChildW'(1);
  assign l_in_heap = lchild < ChildW'(held_q);
  assign r_in_heap = rchild < ChildW'(held_q);
  assign up_swap   = ihq_pkg::outranks(min_order_q, cur_prio_q, rd_prio);
  assign right_wins = has_right_q && ihq_pkg::outranks(min_order_q, rd_prio, left_prio_q);
  assign child_prio  = right_wins ? rd_prio : left_prio_q;
  assign child_owner = right_wins ? rd_owner : left_owner_q;
  assign child_idx   = right_wins ? rchild[IdW-1:0] : lchild[IdW-1:0];
  assign down_swap = ihq_pkg::outranks(min_order_q, child_prio, cur_prio_q);
  assign valid_op  = mode_q <= ihq_pkg::MODE_GET;
  assign lookup_op = (mode_q == ihq_pkg::MODE_CHANGE) || (mode_q == ihq_pkg::MODE_REMOVE) ||
                     (mode_q == ihq_pkg::MODE_GET);

  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.dec_insert = in_range && (mode_q == ihq_pkg::MODE_INSERT) && !id_here;
    stat_o.dec_lookup = in_range && lookup_op && id_here;
    stat_o.dec_take   = (mode_q == ihq_pkg::MODE_DELTOP) && (held_q != '0);
    stat_o.pos_zero   = pos_q == '0;
    stat_o.s_is_last  = s_is_last;
    stat_o.l_in_heap  = l_in_heap;
    stat_o.up_swap    = up_swap;
    stat_o.down_swap  = down_swap;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = pos_q;
    slot_wdata = {cur_owner_q, cur_prio_q};
    slot_re    = 1'b0;
    slot_raddr = '0;
    id_we      = 1'b0;
    id_waddr   = cur_owner_q;
    id_wdata   = pos_q;
    id_re      = 1'b0;
    id_raddr   = id_q;
    unique case (cmd_i)
      ihq_pkg::CMD_DECODE: begin
        id_re   = stat_o.dec_lookup;
        slot_re = stat_o.dec_take;
      end
      ihq_pkg::CMD_LOOKUP: begin
        slot_re    = mode_q == ihq_pkg::MODE_GET;
        slot_raddr = id_rdata;
      end
      ihq_pkg::CMD_REMOVE: begin
        slot_re    = !s_is_last;
        slot_raddr = last[IdW-1:0];
      end
      ihq_pkg::CMD_UP_RD: begin
        slot_re    = pos_q != '0;
        slot_raddr = parent;
      end
      ihq_pkg::CMD_UP_CMP: begin
        slot_we    = up_swap;
        slot_wdata = slot_rdata;
        id_we      = up_swap;
        id_waddr   = rd_owner;
      end
      ihq_pkg::CMD_DOWN_RDL: begin
        slot_re    = l_in_heap;
        slot_raddr = lchild[IdW-1:0];
      end
      ihq_pkg::CMD_DOWN_RDR: begin
        slot_re    = r_in_heap;
        slot_raddr = rchild[IdW-1:0];
      end
      ihq_pkg::CMD_DOWN_CMP: begin
        slot_we    = down_swap;
        slot_wdata = {child_owner, child_prio};
        id_we      = down_swap;
        id_waddr   = child_owner;
      end
      ihq_pkg::CMD_PLACE: begin
        slot_we = 1'b1;
        id_we   = 1'b1;
      end
      ihq_pkg::CMD_TOP_RD: begin
        slot_re = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cap_clamped = cfg_data_i;
    if (cfg_data_i == '0) begin
      cap_clamped = CountW'(1);
    end else if (cfg_data_i > CountW'(ihq_pkg::MaxEntries)) begin
      cap_clamped = CountW'(ihq_pkg::MaxEntries);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_order_q <= 1'b1;
      cap_q       <= CountW'(ihq_pkg::MaxEntries);
      present_q   <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == ihq_pkg::CFG_MIN_ORDER) begin
          min_order_q <= cfg_data_i[0];
        end else begin
          cap_q <= cap_clamped;
        end
      end
      if (cmd_i == ihq_pkg::CMD_LOAD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i)
        ihq_pkg::CMD_DECODE: begin
          if (stat_o.dec_insert) begin
            present_q[id_q] <= 1'b1;
            held_q          <= held_q + CountW'(1);
          end
        end
        ihq_pkg::CMD_LOOKUP: begin
          if (mode_q == ihq_pkg::MODE_REMOVE) begin
            present_q[id_q] <= 1'b0;
          end
        end
        ihq_pkg::CMD_TAKE_TOP: present_q[rd_owner] <= 1'b0;
        ihq_pkg::CMD_REMOVE:   held_q <= last;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      ihq_pkg::CMD_ACCEPT: begin
        mode_q     <= mode_i;
        id_q       <= entry_id_i;
        prio_q     <= new_priority_i;
        st_q       <= ihq_pkg::ST_OK;
        ans_id_q   <= '0;
        ans_prio_q <= '0;
      end
      ihq_pkg::CMD_DECODE: begin
        if (valid_op && (mode_q != ihq_pkg::MODE_DELTOP) && !in_range) begin
          st_q <= ihq_pkg::ST_RANGE;
        end else if (mode_q == ihq_pkg::MODE_INSERT) begin
          if (id_here) begin
            st_q <= ihq_pkg::ST_DUP;
          end
          cur_prio_q  <= prio_q;
          cur_owner_q <= id_q;
          pos_q       <= held_q[IdW-1:0];
        end else if (lookup_op) begin
          if (!id_here) begin
            st_q <= ihq_pkg::ST_ABSENT;
          end
        end else if (mode_q == ihq_pkg::MODE_DELTOP) begin
          if (held_q == '0) begin
            st_q <= ihq_pkg::ST_EMPTY;
          end
        end
      end
      ihq_pkg::CMD_LOOKUP: begin
        pos_q       <= id_rdata;
        cur_prio_q  <= prio_q;
        cur_owner_q <= id_q;
      end
      ihq_pkg::CMD_GET: ans_prio_q <= rd_prio;
      ihq_pkg::CMD_TAKE_TOP: begin
        ans_id_q   <= rd_owner;
        ans_prio_q <= rd_prio;
        pos_q      <= '0;
      end
      ihq_pkg::CMD_FILL: begin
        cur_prio_q  <= rd_prio;
        cur_owner_q <= rd_owner;
      end
      ihq_pkg::CMD_UP_CMP: begin
        if (up_swap) begin
          pos_q <= parent;
        end
      end
      ihq_pkg::CMD_DOWN_RDR: begin
        left_prio_q  <= rd_prio;
        left_owner_q <= rd_owner;
        has_right_q  <= r_in_heap;
      end
      ihq_pkg::CMD_DOWN_CMP: begin
        if (down_swap) begin
          pos_q <= child_idx;
        end
      end
      ihq_pkg::CMD_LOAD_OUT: begin
        out_status_q    <= st_q;
        out_ans_id_q    <= ans_id_q;
        out_ans_prio_q  <= ans_prio_q;
        out_count_q     <= held_q;
        out_top_valid_q <= held_q != '0;
        out_top_id_q    <= (held_q != '0) ? rd_owner : '0;
        out_top_prio_q  <= (held_q != '0) ? rd_prio : '0;
      end
      default: ;
    endcase
  end

  ihq_ram #(.Width(SlotW), .Depth(ihq_pkg::MaxEntries)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  ihq_ram #(.Width(IdW), .Depth(ihq_pkg::MaxEntries)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (id_waddr),
    .wdata_i (id_wdata),
    .re_i    (id_re),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign answer_id_o       = out_ans_id_q;
  assign answer_priority_o = out_ans_prio_q;
  assign top_valid_o       = out_top_valid_q;
  assign top_id_o          = out_top_id_q;
  assign top_priority_o    = out_top_prio_q;
  assign entry_count_o     = out_count_q;

endmodule

### src/indexed_binary_heap_queue_top.sv
// indexed_binary_heap_queue_top: indexed min/max heap priority queue
// depends on ihq_pkg, ihq_ctrl, ihq_dp (which holds the ihq_ram instances)
//
//  channel  handshake                    payload
//  in       in_valid_i / in_ready_o      mode_i, entry_id_i, new_priority_i
//  out      out_valid_o / out_ready_i    status_o .. entry_count_o
//  cfg      cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// an item that only reports a status passes decode, top read and done before the
// next free input, get priority adds the lookup and get states, and delete top
// a full sift-down; each heap level takes a read and a compare going up and two
// reads and a compare going down through the single read port of the slot ram
// reset clears the presence bits and count; the rams need no clearing
// a new item is taken once the previous one is in the output register
// a stalled output transfer holds the next result in its final state

module indexed_binary_heap_queue_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [ihq_pkg::CountW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ihq_pkg::ModeW-1:0]        mode_i,
  input  logic [ihq_pkg::IdW-1:0]          entry_id_i,
  input  logic signed [ihq_pkg::PrioW-1:0] new_priority_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ihq_pkg::StatusW-1:0]      status_o,
  output logic [ihq_pkg::IdW-1:0]          answer_id_o,
  output logic signed [ihq_pkg::PrioW-1:0] answer_priority_o,
  output logic                             top_valid_o,
  output logic [ihq_pkg::IdW-1:0]          top_id_o,
  output logic signed [ihq_pkg::PrioW-1:0] top_priority_o,
  output logic [ihq_pkg::CountW-1:0]       entry_count_o
);

  ihq_pkg::cmd_e  cmd;
  ihq_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  ihq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ihq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mode_i            (mode_i),
    .entry_id_i        (entry_id_i),
    .new_priority_i    (new_priority_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .answer_id_o       (answer_id_o),
    .answer_priority_o (answer_priority_o),
    .top_valid_o       (top_valid_o),
    .top_id_o          (top_id_o),
    .top_priority_o    (top_priority_o),
    .entry_count_o     (entry_count_o)
  );

endmodule
